FILE: rtl/mdio_management_master_unit_defines.svh
// Assertion macros for the MDIO management master RTL.
`ifndef MDIO_MANAGEMENT_MASTER_UNIT_DEFINES_SVH
`define MDIO_MANAGEMENT_MASTER_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
// property that must hold at every edge out of reset
`define MDIOM_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// antecedent in this cycle implies consequent in the next
`define MDIOM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define MDIOM_ASSERT(lbl, clk, rst_n, prop, msg)
`define MDIOM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: rtl/mdiom_pkg.sv
// Types and constants of the MDIO management master.
package mdiom_pkg;

	// frame geometry
	localparam int unsigned PREAMBLE_LEN = 32;
	localparam int unsigned FRAME_BITS   = 32;
	localparam int unsigned TOTAL_BITS   = PREAMBLE_LEN + FRAME_BITS;
	localparam int unsigned DATA_START   = PREAMBLE_LEN + 16;
	localparam int unsigned DRIVE_LIMIT  = 14;

	// command register layout
	localparam int unsigned CMD_BUSY_BIT = 0;
	localparam int unsigned CMD_WR_BIT   = 1;
	localparam int unsigned CMD_REG_LSB  = 4;
	localparam int unsigned CMD_PHY_LSB  = 12;
	localparam int unsigned CMD_DIV_LSB  = 20;

	// request kinds
	typedef enum logic [1:0] {
		MODE_WRITE = 2'd0,
		MODE_READ  = 2'd1,
		MODE_TICK  = 2'd2
	} mode_t;

	// bus targets
	localparam logic SEL_CMD  = 1'b0;
	localparam logic SEL_DATA = 1'b1;

	// opcode and turnaround patterns
	localparam logic [1:0] OP_WRITE = 2'b01;
	localparam logic [1:0] OP_READ  = 2'b10;
	localparam logic [1:0] TA_WRITE = 2'b10;
	localparam logic [1:0] TA_READ  = 2'b00;
	localparam logic [1:0] START_PATTERN = 2'b01;

	// one request
	typedef struct packed {
		logic [1:0]  mode;
		logic        reg_select;
		logic [31:0] write_data;
		logic        mdio_in;
	} req_t;

	// one result
	typedef struct packed {
		logic [31:0] read_data;
		logic        mdc;
		logic        mdio_out;
		logic        mdio_drive;
		logic        busy_res;
	} res_t;

endpackage

FILE: rtl/mdiom_core.sv
// Register file, MDC divider and clause-22 frame sequencer.
`include "mdio_management_master_unit_defines.svh"

module mdiom_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  mdiom_pkg::req_t   req,
	input  logic              cfg_wr_en,
	input  logic [1:0]        cfg_wr_data,
	output mdiom_pkg::res_t   res
);
	import mdiom_pkg::*;

	localparam logic [6:0] PRE_L   = 7'(PREAMBLE_LEN);
	localparam logic [6:0] TOTAL_L = 7'(TOTAL_BITS);
	localparam logic [6:0] DATA_L  = 7'(DATA_START);
	localparam logic [6:0] DRV_L   = 7'(DRIVE_LIMIT);
	localparam logic [6:0] LAST_Q  = 7'(FRAME_BITS - 1);

	logic [1:0]  div_sel_q;
	logic [4:0]  phy_q, phy_d;
	logic [4:0]  reg_q, reg_d;
	logic        wr_q, wr_d;
	logic        busy_q, busy_d;
	logic [15:0] data_q, data_d;
	logic [5:0]  div_q, div_d;
	logic [5:0]  bit_q, bit_d;
	logic [31:0] frame_q, frame_d;
	logic        mdc_q, mdc_d;

	logic [31:0] rd;
	logic [6:0]  half;
	logic [6:0]  div_inc;
	logic [6:0]  bit_inc;
	logic [6:0]  pos;
	logic [6:0]  q;
	logic        line_out;
	logic        line_drv;

	// divider select register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_sel_q <= '0;
		end else if (cfg_wr_en) begin
			div_sel_q <= cfg_wr_data;
		end
	end

	// next state for the request in flight
	always_comb begin
		phy_d   = phy_q;
		reg_d   = reg_q;
		wr_d    = wr_q;
		busy_d  = busy_q;
		data_d  = data_q;
		div_d   = div_q;
		bit_d   = bit_q;
		frame_d = frame_q;
		mdc_d   = mdc_q;
		rd      = '0;
		half    = 7'd8 << div_sel_q;
		div_inc = {1'b0, div_q} + 7'd1;
		bit_inc = {1'b0, bit_q} + 7'd1;
		case (mode_t'(req.mode))
			MODE_WRITE: begin
				if (!busy_q) begin
					if (req.reg_select == SEL_CMD) begin
						phy_d  = req.write_data[CMD_PHY_LSB +: 5];
						reg_d  = req.write_data[CMD_REG_LSB +: 5];
						wr_d   = req.write_data[CMD_WR_BIT];
						busy_d = req.write_data[CMD_BUSY_BIT];
						if (req.write_data[CMD_BUSY_BIT]) begin
							frame_d = {START_PATTERN,
								req.write_data[CMD_WR_BIT] ? OP_WRITE : OP_READ,
								req.write_data[CMD_PHY_LSB +: 5],
								req.write_data[CMD_REG_LSB +: 5],
								req.write_data[CMD_WR_BIT] ? TA_WRITE : TA_READ,
								req.write_data[CMD_WR_BIT] ? data_q : 16'h0000};
							bit_d = '0;
							div_d = '0;
							mdc_d = 1'b0;
						end
					end else begin
						data_d = req.write_data[15:0];
					end
				end
			end
			MODE_READ: begin
				if (req.reg_select == SEL_CMD) begin
					rd[CMD_DIV_LSB +: 2] = div_sel_q;
					rd[CMD_PHY_LSB +: 5] = phy_q;
					rd[CMD_REG_LSB +: 5] = reg_q;
					rd[CMD_WR_BIT]       = wr_q;
					rd[CMD_BUSY_BIT]     = busy_q;
				end else begin
					rd[15:0] = data_q;
				end
			end
			MODE_TICK: begin
				if (busy_q) begin
					if (div_inc < half) begin
						div_d = div_inc[5:0];
					end else begin
						div_d = '0;
						if (!mdc_q) begin
							// rising MDC: sample the PHY in the data phase of a read
							mdc_d = 1'b1;
							if (!wr_q && {1'b0, bit_q} >= DATA_L) begin
								data_d = {data_q[14:0], req.mdio_in};
							end
						end else begin
							// falling MDC: advance to the next bit, or end the frame after the last
							mdc_d = 1'b0;
							if (bit_inc >= TOTAL_L) begin
								busy_d = 1'b0;
								bit_d  = '0;
							end else begin
								bit_d = bit_inc[5:0];
							end
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	// line levels after the update
	always_comb begin
		line_out = 1'b0;
		line_drv = 1'b0;
		pos      = {1'b0, bit_d};
		q        = pos - PRE_L;
		if (busy_d) begin
			if (pos < PRE_L) begin
				line_out = 1'b1;
				line_drv = 1'b1;
			end else if (q <= LAST_Q) begin
				if (wr_d || q < DRV_L) begin
					line_drv = 1'b1;
					line_out = frame_d[5'(LAST_Q - q)];
				end
			end
		end
	end

	assign res.read_data  = rd;
	assign res.mdc        = mdc_d;
	assign res.mdio_out   = line_out;
	assign res.mdio_drive = line_drv;
	assign res.busy_res   = busy_d;

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phy_q   <= '0;
			reg_q   <= '0;
			wr_q    <= 1'b0;
			busy_q  <= 1'b0;
			data_q  <= '0;
			div_q   <= '0;
			bit_q   <= '0;
			frame_q <= '0;
			mdc_q   <= 1'b0;
		end else if (en) begin
			phy_q   <= phy_d;
			reg_q   <= reg_d;
			wr_q    <= wr_d;
			busy_q  <= busy_d;
			data_q  <= data_d;
			div_q   <= div_d;
			bit_q   <= bit_d;
			frame_q <= frame_d;
			mdc_q   <= mdc_d;
		end
	end

	`MDIOM_ASSERT(a_idle_clean, clk, arst_n, !busy_q |-> (bit_q == '0 && !mdc_q && div_q == '0), "idle sequencer not parked")
	`MDIOM_ASSERT(a_start_bits, clk, arst_n, $rose(busy_q) |-> (frame_q[31:30] == START_PATTERN), "frame started without start bits")
	`MDIOM_ASSERT_NEXT(a_hold_no_req, clk, arst_n, !en, $stable(data_q) && $stable(busy_q) && $stable(bit_q), "state moved without a request")

endmodule

FILE: rtl/mdio_management_master_unit.sv
// Top level of the MDIO management master: input and result registers around the core.
// A request is registered in the input stage, then its core result in the output register.
// One request per cycle when not stalled; the core updates all state in one pass per request.
// A stalled result holds in the output register while one more request waits in the input stage.
// Reset: arst_n async-clears core state and valid flags; divider select /16, no frame running.
module mdio_management_master_unit (
	input  logic        clk,
	input  logic        arst_n,
	// configuration: MDC divider select
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_wr_data,
	// request side
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // [31:0] write_data, [32] mdio_in, [39:33] zero
	input  logic [2:0]  s_axis_tuser,  // [1:0] mode, [2] reg_select
	// result side
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata   // [31:0] read_data, [32] mdc, [33] mdio_out,
	                                   // [34] mdio_drive, [35] busy_res, [39:36] zero
);
	import mdiom_pkg::*;

	req_t req_s1;
	logic valid_s1;
	res_t res_c;
	res_t res_s2;
	logic valid_s2;
	logic advance;
	logic s_accept;

	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign s_accept      = s_axis_tvalid && s_axis_tready;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			req_s1.mode       <= s_axis_tuser[1:0];
			req_s1.reg_select <= s_axis_tuser[2];
			req_s1.write_data <= s_axis_tdata[31:0];
			req_s1.mdio_in    <= s_axis_tdata[32];
		end
	end

	mdiom_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (advance),
		.req         (req_s1),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.res         (res_c)
	);

	// result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_c;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {4'b0000, res_s2.busy_res, res_s2.mdio_drive, res_s2.mdio_out,
		res_s2.mdc, res_s2.read_data};

endmodule
